/* rtl/cir_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_pkg: shared definitions for the current interlocked reverser
// Mode codes, register indexes, field widths and the relay and LED patterns.
// ----------------------------------------------------------------------------
package cir_pkg;

  localparam int THR_W      = 19;
  localparam int DEB_W      = 16;
  localparam int STABLE_W   = 17;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int OUT_DATA_W = 16;

  localparam logic [STABLE_W-1:0] STABLE_MAX = '1;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(2185);
  localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(100);

  // Register index, taken from paddr[2].
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_DEBOUNCE  = 1'b1;

  typedef enum logic [1:0] {
    MODE_REST = 2'd0,
    MODE_A    = 2'd1,
    MODE_TO_B = 2'd2,
    MODE_B    = 2'd3
  } mode_t;

  localparam logic [3:0] RELAY_A    = 4'd9;
  localparam logic [3:0] RELAY_B    = 4'd6;
  localparam logic [3:0] RELAY_NONE = 4'd0;

  function automatic logic [3:0] relay_of(input mode_t m);
    logic [3:0] r;
    unique case (m)
      MODE_A:  r = RELAY_A;
      MODE_B:  r = RELAY_B;
      default: r = RELAY_NONE;
    endcase
    return r;
  endfunction

  // Bits 2..0 of the LED pattern: direction B, direction A, rest.
  function automatic logic [2:0] led_mode_of(input mode_t m);
    logic [2:0] l;
    unique case (m)
      MODE_A:  l = 3'b010;
      MODE_B:  l = 3'b100;
      default: l = 3'b001;
    endcase
    return l;
  endfunction

endpackage

/* rtl/cir_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_cell: one sample cell of the averaging window
// Holds one sample and takes its neighbor's sample on each shift.
// ----------------------------------------------------------------------------
module cir_cell #(
  parameter int WIDTH = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    shift,
  input  logic signed [WIDTH-1:0] d,
  output logic signed [WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

/* rtl/cir_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_window: sample window with running sum
// A chain of cells holds the newest samples; the sum follows each shift.
// ----------------------------------------------------------------------------
module cir_window #(
  parameter int WINDOW_LEN  = 8,
  parameter int SAMPLE_BITS = 20,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW_LEN)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] last_sample,
  output logic signed [SUM_W-1:0]       window_sum
);

  logic signed [SAMPLE_BITS-1:0] tap [0:WINDOW_LEN];

  assign tap[0] = sample_in;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    cir_cell #(
      .WIDTH(SAMPLE_BITS)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(shift),
      .d    (tap[i]),
      .q    (tap[i+1])
    );
  end

  // The sample falling off the end of the chain leaves the sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum  <= '0;
      last_sample <= '0;
    end else if (shift) begin
      window_sum  <= window_sum + SUM_W'(sample_in) - SUM_W'(tap[WINDOW_LEN]);
      last_sample <= sample_in;
    end
  end

endmodule

/* rtl/current_interlocked_reverser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// current_interlocked_reverser: push-button direction reverser with interlock
// Debounced presses step the mode; presses are refused while current flows.
// ----------------------------------------------------------------------------
// One tick transfer is accepted every clock cycle unless the output stalls. The
// first register stage updates the sample window chain, the running sum and
// the debounce counter, and the output stage then decides the press and
// registers the relay and LED patterns. The window chain shifts once per valid
// sample, so the rate is one tick per cycle whatever the samples, while not stalled.
// When the output is stalled, at most two ticks are held inside the block.
module current_interlocked_reverser
  import cir_pkg::*;
#(
  parameter int WINDOW_LEN  = 8,
  parameter int SAMPLE_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: button_level [0], current_sample [SAMPLE_BITS:1], zero fill above
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [((SAMPLE_BITS+8)/8)*8-1:0] s_tdata,
  // s_tuser: sample_valid [0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata: mode [1:0], relay_bits [5:2], led_bits [9:6], press_blocked [10],
  // press_taken [11], zero fill [15:12]
  output logic [OUT_DATA_W-1:0]          m_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [PADDR_W-1:0]             paddr,
  input  logic [PDATA_W-1:0]             pwdata,
  output logic [PDATA_W-1:0]             prdata,
  output logic                           pready
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int MAG_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int LIM_W = THR_W + $clog2(WINDOW_LEN) + 1;
  localparam int CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;

  // Configuration registers
  logic [THR_W-1:0] current_threshold;
  logic [DEB_W-1:0] debounce_ticks;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_threshold <= THR_RESET;
      debounce_ticks    <= DEB_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_THRESHOLD: current_threshold <= pwdata[THR_W-1:0];
        REG_DEBOUNCE:  debounce_ticks    <= pwdata[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = PDATA_W'(current_threshold);
      REG_DEBOUNCE:  prdata = PDATA_W'(debounce_ticks);
      default:       prdata = '0;
    endcase
  end

  // Handshake and stage control
  logic stage_valid;
  logic out_advance;
  logic in_accept;

  assign out_advance = !m_tvalid || m_tready;
  assign s_tready    = !stage_valid || out_advance;
  assign in_accept   = s_tvalid && s_tready;

  logic                          in_level;
  logic                          in_sample_valid;
  logic signed [SAMPLE_BITS-1:0] in_sample;

  assign in_level        = s_tdata[0];
  assign in_sample       = s_tdata[SAMPLE_BITS:1];
  assign in_sample_valid = s_tuser;

  // First stage: sample window, current flag and debounce counter
  logic signed [SAMPLE_BITS-1:0] last_sample;
  logic signed [SUM_W-1:0]       window_sum;
  logic                          current_present;
  logic [STABLE_W-1:0]           stable_count;
  logic                          prev_level;
  logic [SAMPLE_BITS-1:0]        in_mag;

  cir_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_W      (SUM_W)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .shift      (in_accept && in_sample_valid),
    .sample_in  (in_sample),
    .last_sample(last_sample),
    .window_sum (window_sum)
  );

  assign in_mag = in_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_sample)
                                            : SAMPLE_BITS'(in_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid     <= 1'b0;
      current_present <= 1'b0;
      stable_count    <= '0;
      prev_level      <= 1'b1;
    end else begin
      if (in_accept) begin
        stage_valid <= 1'b1;
      end else if (out_advance) begin
        stage_valid <= 1'b0;
      end
      if (in_accept) begin
        if (in_sample_valid) begin
          current_present <= (MAG_W'(in_mag) >= MAG_W'(current_threshold));
        end
        if (in_level != prev_level) begin
          stable_count <= '0;
        end else if (stable_count != STABLE_MAX) begin
          stable_count <= stable_count + 1'b1;
        end
        prev_level <= in_level;
      end
    end
  end

  // Output stage: press decision on the state left by the tick in stage one
  mode_t                  mode;
  mode_t                  mode_next;
  logic                   press_latched;
  logic                   press_latched_next;
  logic                   qualify;
  logic                   interlock_ok;
  logic [SUM_W-1:0]       sum_mag;
  logic [SAMPLE_BITS-1:0] last_mag;
  logic [CMP_W-1:0]       sum_limit;
  logic [3:0]             relay_bits;
  logic [3:0]             led_bits;
  logic                   press_blocked;
  logic                   press_taken;

  assign sum_mag   = window_sum[SUM_W-1] ? SUM_W'(-window_sum) : SUM_W'(window_sum);
  assign last_mag  = last_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-last_sample)
                                                : SAMPLE_BITS'(last_sample);
  assign sum_limit = CMP_W'(current_threshold) * CMP_W'(WINDOW_LEN);

  assign interlock_ok = (CMP_W'(sum_mag) < sum_limit) &&
                        (MAG_W'(last_mag) < MAG_W'(current_threshold));
  assign qualify = (stable_count > STABLE_W'(debounce_ticks)) && !prev_level &&
                   !press_latched;

  always_comb begin
    mode_next          = mode;
    press_latched_next = press_latched;
    if (qualify) begin
      press_latched_next = 1'b1;
      if (interlock_ok) begin
        mode_next = mode_t'(mode + 2'd1);
      end
    end
    // A release ends the hold, so the next press may count again.
    if (prev_level) begin
      press_latched_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      mode          <= MODE_REST;
      press_latched <= 1'b0;
      relay_bits    <= RELAY_NONE;
      led_bits      <= 4'b0001;
      press_blocked <= 1'b0;
      press_taken   <= 1'b0;
    end else if (out_advance) begin
      m_tvalid <= stage_valid;
      if (stage_valid) begin
        mode          <= mode_next;
        press_latched <= press_latched_next;
        relay_bits    <= relay_of(mode_next);
        led_bits      <= {current_present, led_mode_of(mode_next)};
        press_blocked <= qualify && !interlock_ok;
        press_taken   <= qualify && interlock_ok;
      end
    end
  end

  assign m_tdata = {4'b0000, press_taken, press_blocked, led_bits, relay_bits, mode};

endmodule

/* rtl/cir_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_checker: port-level checks for the current interlocked reverser
// Watches the result stream and is bound to the top level.
// ----------------------------------------------------------------------------
module cir_checker
  import cir_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A stalled result transfer keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A press is either taken or blocked, never both.
  a_press_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[10] && m_tdata[11]))
    else $error("press both taken and blocked");

  // Relays follow the reported mode.
  a_relay: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[5:2] == relay_of(mode_t'(m_tdata[1:0])))
    else $error("relay pattern does not match mode");

  // Exactly one mode LED is lit and it matches the mode.
  a_led: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tdata[8:6]) &&
                 m_tdata[8:6] == led_mode_of(mode_t'(m_tdata[1:0])))
    else $error("mode LEDs do not match mode");

  // A taken press moves the mode one step from the previous result.
  a_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready ##1 m_tvalid && m_tdata[11] |->
      m_tdata[1:0] == $past(m_tdata[1:0], 1) + 2'd1 ||
      !$past(m_tvalid && m_tready, 1))
    else $error("taken press did not advance mode by one");

endmodule

bind current_interlocked_reverser cir_checker u_cir_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

/* tb/cir_tick_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_tick_checker: scoreboard for the current interlocked reverser
// Follows the tick and result streams and the register port. Each tick that
// is accepted updates a private copy of the sample window, the debounce state
// and the mode, and the expected result is queued. Each result that is
// accepted is compared field by field with the oldest expected one. Register
// reads are checked against the register copy.
// ----------------------------------------------------------------------------
module cir_tick_checker
  import cir_pkg::*;
#(
  parameter int WINDOW_LEN  = 8,
  parameter int SAMPLE_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [((SAMPLE_BITS+8)/8)*8-1:0]   s_tdata,
  input  logic                               s_tuser,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [OUT_DATA_W-1:0]              m_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [PADDR_W-1:0]                 paddr,
  input  logic [PDATA_W-1:0]                 pwdata,
  input  logic [PDATA_W-1:0]                 prdata,
  input  logic                               pready,
  output int                                 mismatches,
  output int                                 results_due
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int PTR_W = $clog2(WINDOW_LEN);

  // Members from the top bit down, so the struct lines up with m_tdata[11:0].
  typedef struct packed {
    logic       taken;
    logic       blocked;
    logic [3:0] led;
    logic [3:0] relay;
    mode_t      mode;
  } tick_result_t;

  logic [THR_W-1:0]              limit_q;
  logic [DEB_W-1:0]              settle_q;
  mode_t                         mode_q;
  logic signed [SAMPLE_BITS-1:0] window [WINDOW_LEN];
  logic [PTR_W-1:0]              wr_ptr;
  logic signed [SUM_W-1:0]       window_total;
  logic signed [SAMPLE_BITS-1:0] newest;
  logic                          over_limit;
  logic [STABLE_W-1:0]           hold_ticks;
  logic                          last_level;
  logic                          press_held;
  tick_result_t                  tick_results_due [$];

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic advance_tick(input logic lvl, input logic vld,
                              input logic signed [SAMPLE_BITS-1:0] smp,
                              output tick_result_t res);
    res = '0;
    if (vld) begin
      newest = smp;
      // Intermediate wrap is harmless: the final total always fits SUM_W.
      window_total = window_total + smp - window[wr_ptr];
      window[wr_ptr] = smp;
      wr_ptr = (wr_ptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : wr_ptr + 1'b1;
      over_limit = magnitude(longint'(smp)) >= longint'(limit_q);
    end

    if (lvl != last_level) begin
      hold_ticks = '0;
    end else if (hold_ticks != STABLE_MAX) begin
      hold_ticks = hold_ticks + 1'b1;
    end

    // A press counts once per hold, whether it is taken or refused.
    if (hold_ticks > settle_q && !lvl && !press_held) begin
      press_held = 1'b1;
      if (magnitude(longint'(window_total)) < WINDOW_LEN * longint'(limit_q) &&
          magnitude(longint'(newest)) < longint'(limit_q)) begin
        mode_q = mode_t'(mode_q + 2'd1);
        res.taken = 1'b1;
      end else begin
        res.blocked = 1'b1;
      end
    end
    if (lvl) begin
      press_held = 1'b0;
    end
    last_level = lvl;

    res.mode = mode_q;
    case (mode_q)
      MODE_A: begin
        res.relay = RELAY_A;
        res.led   = {over_limit, 3'b010};
      end
      MODE_B: begin
        res.relay = RELAY_B;
        res.led   = {over_limit, 3'b100};
      end
      default: begin
        res.relay = RELAY_NONE;
        res.led   = {over_limit, 3'b001};
      end
    endcase
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    tick_result_t got;
    logic [PDATA_W-1:0] reg_val;
    if (rst) begin
      limit_q      = THR_RESET;
      settle_q     = DEB_RESET;
      mode_q       = MODE_REST;
      foreach (window[i]) window[i] = '0;
      wr_ptr       = '0;
      window_total = '0;
      newest       = '0;
      over_limit   = 1'b0;
      hold_ticks   = '0;
      last_level   = 1'b1;
      press_held   = 1'b0;
      tick_results_due.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        advance_tick(s_tdata[0], s_tuser, s_tdata[SAMPLE_BITS:1], want);
        tick_results_due.push_back(want);
      end

      if (m_tvalid && m_tready) begin
        got = tick_result_t'(m_tdata[11:0]);
        if (tick_results_due.size() == 0) begin
          $error("result transfer with no tick outstanding: %h", m_tdata);
          mismatches++;
        end else begin
          want = tick_results_due.pop_front();
          if (got.mode !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, got.mode);
            mismatches++;
          end
          if (got.relay !== want.relay) begin
            $error("relay_bits: expected %0d, got %0d", want.relay, got.relay);
            mismatches++;
          end
          if (got.led !== want.led) begin
            $error("led_bits: expected %0d, got %0d", want.led, got.led);
            mismatches++;
          end
          if (got.blocked !== want.blocked) begin
            $error("press_blocked: expected %0d, got %0d", want.blocked, got.blocked);
            mismatches++;
          end
          if (got.taken !== want.taken) begin
            $error("press_taken: expected %0d, got %0d", want.taken, got.taken);
            mismatches++;
          end
        end
      end

      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[2])
            REG_THRESHOLD: limit_q  = pwdata[THR_W-1:0];
            REG_DEBOUNCE:  settle_q = pwdata[DEB_W-1:0];
            default: ;
          endcase
        end else begin
          reg_val = (paddr[2] == REG_THRESHOLD) ? PDATA_W'(limit_q) : PDATA_W'(settle_q);
          if (prdata !== reg_val) begin
            $error("prdata at %0d: expected %0d, got %0d", paddr, reg_val, prdata);
            mismatches++;
          end
        end
      end
    end
    results_due = tick_results_due.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the current interlocked reverser
// Drives millisecond ticks through the input stream with a short directed
// opening, then button hold sequences with random current samples under
// several threshold and debounce settings and idle patterns, and a final
// long hold past a longer debounce time. Checking is done by
// cir_tick_checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import cir_pkg::*;

  localparam int WINDOW_LEN   = 8;
  localparam int SAMPLE_BITS  = 20;
  localparam int IN_DATA_W    = ((SAMPLE_BITS+8)/8)*8;
  localparam int CYCLE_LIMIT  = 100_000;
  localparam int STALL_CYCLES = 64;
  localparam int PHASE_TICKS  = 170;
  localparam int FINAL_DEB    = 48;
  // Long enough to pass the debounce time of the final hold.
  localparam int LONG_HOLD    = 60;
  localparam int MAX_THR      = 2**THR_W - 1;

  localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = PADDR_W'({REG_THRESHOLD, 2'b00});
  localparam logic [PADDR_W-1:0] ADDR_DEBOUNCE  = PADDR_W'({REG_DEBOUNCE, 2'b00});

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [PADDR_W-1:0]    paddr    = '0;
  logic [PDATA_W-1:0]    pwdata   = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  int mismatches;
  int results_due;
  int snd_idle = 38;
  int rcv_idle = 68;
  int ticks_sent = 0;
  int threshold_now = 2185;
  int debounce_now = 100;
  int cycles = 0;
  bit stall_toggle = 1'b0;
  bit stall_seen = 1'b0;
  int stall_left = 0;

  current_interlocked_reverser #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  cir_tick_checker #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Result side. A toggle of stall_toggle starts one long hold-off, during
  // which the block fills up and must stall its input.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (stall_toggle != stall_seen) begin
      stall_seen = stall_toggle;
      stall_left = STALL_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic send_tick(input logic lvl, input logic vld,
                           input logic [SAMPLE_BITS-1:0] smp);
    while ($urandom_range(99) < snd_idle) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= vld;
    s_tdata  <= IN_DATA_W'({smp, lvl});
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stop offering ticks and wait until every result has been taken.
  task automatic quiesce();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input int thr, input int deb);
    logic [PDATA_W-1:0] word;
    quiesce();
    // Upper bits carry noise; the registers keep only their own width.
    word = $urandom;
    word[THR_W-1:0] = THR_W'(thr);
    apb_access(1'b1, ADDR_THRESHOLD, word);
    word = $urandom;
    word[DEB_W-1:0] = DEB_W'(deb);
    apb_access(1'b1, ADDR_DEBOUNCE, word);
    apb_access(1'b0, ADDR_THRESHOLD, '0);
    apb_access(1'b0, ADDR_DEBOUNCE, '0);
    threshold_now = thr;
    debounce_now  = deb;
  endtask

  // Mostly currents well below the limit, some right at it, some anywhere.
  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    int mag;
    case ($urandom_range(9))
      8: return SAMPLE_BITS'($urandom);
      9: begin
        case ($urandom_range(3))
          0: return SAMPLE_MIN;
          1: return SAMPLE_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      6, 7: mag = threshold_now + int'($urandom_range(3)) - 2;
      default: mag = int'($urandom_range(threshold_now / 4));
    endcase
    if (mag < 0) mag = 0;
    return SAMPLE_BITS'($urandom_range(1) ? -mag : mag);
  endfunction

  // Release, an optional bounce, then a hold that usually qualifies.
  task automatic press_sequence();
    int rel_len;
    int push_len;
    rel_len = $urandom_range(debounce_now + 3, 1);
    repeat (rel_len) send_tick(1'b1, $urandom_range(99) < 60, rand_sample());
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(4, 1))
        send_tick(1'($urandom_range(1)), $urandom_range(99) < 60, rand_sample());
    end
    if ($urandom_range(6) == 0) begin
      push_len = $urandom_range(debounce_now + 1, 1);
    end else begin
      push_len = debounce_now + $urandom_range(6, 2);
    end
    repeat (push_len) send_tick(1'b0, $urandom_range(99) < 60, rand_sample());
  endtask

  task automatic run_phase(input int thr, input int deb);
    int start;
    set_config(thr, deb);
    start = ticks_sent;
    press_sequence();
    stall_toggle = ~stall_toggle;
    while (ticks_sent - start < PHASE_TICKS) begin
      if ($urandom_range(9) < 8) begin
        press_sequence();
      end else begin
        repeat (8) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                             SAMPLE_BITS'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apb_access(1'b0, ADDR_THRESHOLD, '0);
    apb_access(1'b0, ADDR_DEBOUNCE, '0);

    // Largest threshold and no debounce time.
    set_config(MAX_THR, 0);
    // A full window of the most negative current, then a sample that is not valid.
    repeat (WINDOW_LEN) send_tick(1'b1, 1'b1, SAMPLE_MIN);
    send_tick(1'b1, 1'b0, SAMPLE_MAX);
    // The press is refused and not retried while the button stays down.
    repeat (3) send_tick(1'b0, 1'b0, '0);
    // A zero sample clears the last reading, so the next press is taken.
    send_tick(1'b1, 1'b1, '0);
    repeat (2) send_tick(1'b0, 1'b0, '0);
    // The largest positive sample sits exactly at the limit.
    send_tick(1'b1, 1'b1, SAMPLE_MAX);
    repeat (2) send_tick(1'b0, 1'b0, '0);
    send_tick(1'b1, 1'b1, '1);
    repeat (2) send_tick(1'b0, 1'b0, '0);

    // With a zero threshold every press is refused.
    set_config(0, 0);
    send_tick(1'b1, 1'b1, '0);
    repeat (2) send_tick(1'b0, 1'b0, '0);

    run_phase(2185, 3);
    run_phase(600, 0);

    snd_idle = 68;
    rcv_idle = 38;
    run_phase(40, 1);
    run_phase(MAX_THR, 2);

    snd_idle = 0;
    rcv_idle = 0;
    run_phase(0, 4);
    run_phase(1, 0);
    run_phase($urandom_range(MAX_THR), $urandom_range(7));

    // A longer debounce time: one long hold takes or refuses a single press.
    set_config(2185, FINAL_DEB);
    repeat (4) send_tick(1'b1, 1'b1, rand_sample());
    repeat (LONG_HOLD) send_tick(1'b0, $urandom_range(7) == 0, rand_sample());
    repeat (3) send_tick(1'b1, 1'b0, '0);
    repeat (3) send_tick(1'b0, 1'b1, rand_sample());

    quiesce();
    repeat (6) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* current_interlocked_reverser.f */
rtl/cir_pkg.sv
rtl/cir_cell.sv
rtl/cir_window.sv
rtl/current_interlocked_reverser.sv
rtl/cir_checker.sv
tb/cir_tick_checker.sv
tb/tb_top.sv
